FILE: rtl/ypd_pkg.sv
package ypd_pkg;

  // Payload sizes in bytes
  localparam int unsigned SHORT_PAYLOAD = 128;
  localparam int unsigned LONG_PAYLOAD  = 1024;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CRC_W    = 16;

  // Framing byte codes
  localparam logic [BYTE_W-1:0] CODE_SOH = 8'h01;
  localparam logic [BYTE_W-1:0] CODE_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CODE_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] CODE_CAN = 8'h18;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CORRUPT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EOT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ABORT   = 3'd5;

  // CRC-16/XMODEM
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
  localparam logic [BYTE_W-1:0] SEQ_MASK = 8'hff;

  localparam logic [LEN_W-1:0] SHORT_LEN = LEN_W'(SHORT_PAYLOAD);
  localparam logic [LEN_W-1:0] LONG_LEN  = LEN_W'(LONG_PAYLOAD);

  // Receiver phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CANWAIT,
    PH_SEQ,
    PH_SEQC,
    PH_DATA,
    PH_CRCHI,
    PH_CRCLO
  } phase_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;     // echo byte, zero on timeout
    logic              stop;     // timeout or cancel
    logic              is_start; // SOH or STX
    logic              is_long;  // STX
    logic              is_eot;
    logic              is_can;
  } item_t;

  // Result word
  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                payload_valid;
    logic                packet_done;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    pay_len;
    logic [BYTE_W-1:0]   block_number;
  } result_t;

  // Byte-wide CRC-16/XMODEM update, MSB first
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/ypd_in_if.sv
interface ypd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timed_out;
  logic       cancel;

  modport source (output valid, output rx_byte, output timed_out, output cancel,
                  input ready);
  modport sink (input valid, input rx_byte, input timed_out, input cancel,
                output ready);
endinterface

FILE: rtl/ypd_out_if.sv
interface ypd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        payload_valid;
  logic        packet_done;
  logic [2:0]  status;
  logic [10:0] pay_len;
  logic [7:0]  block_number;

  modport source (output valid, output out_byte, output payload_valid,
                  output packet_done, output status, output pay_len,
                  output block_number, input ready);
  modport sink (input valid, input out_byte, input payload_valid,
                input packet_done, input status, input pay_len,
                input block_number, output ready);
endinterface

FILE: rtl/ypd_front.sv
module ypd_front (
  ypd_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output ypd_pkg::item_t  push_item
);

  // Accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Classify the word independent of receiver phase
  always_comb begin
    push_item.data     = in_ch.timed_out ? '0 : in_ch.rx_byte;
    push_item.stop     = in_ch.timed_out || in_ch.cancel;
    push_item.is_start = (in_ch.rx_byte == ypd_pkg::CODE_SOH) ||
                         (in_ch.rx_byte == ypd_pkg::CODE_STX);
    push_item.is_long  = (in_ch.rx_byte == ypd_pkg::CODE_STX);
    push_item.is_eot   = (in_ch.rx_byte == ypd_pkg::CODE_EOT);
    push_item.is_can   = (in_ch.rx_byte == ypd_pkg::CODE_CAN);
  end

endmodule

FILE: rtl/ypd_queue.sv
module ypd_queue #(
  parameter int unsigned DEPTH = ypd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ypd_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output ypd_pkg::item_t  pop_item,
  output logic            empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ypd_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/ypd_back.sv
module ypd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  ypd_pkg::item_t  q_item,
  output logic            pop,
  ypd_out_if.source       out_ch
);

  ypd_pkg::phase_t                  phase_r, phase_nxt;
  logic [ypd_pkg::LEN_W-1:0]        byte_count_r, byte_count_nxt;
  logic                             long_r, long_nxt;
  logic [ypd_pkg::BYTE_W-1:0]       seq_r, seq_nxt;
  logic [ypd_pkg::BYTE_W-1:0]       seqc_r, seqc_nxt;
  logic [ypd_pkg::CRC_W-1:0]        crc_r, crc_nxt;
  logic [ypd_pkg::CRC_W-1:0]        crc_upd;
  logic [ypd_pkg::LEN_W-1:0]        size;
  logic [ypd_pkg::LEN_W-1:0]        count_inc;
  ypd_pkg::result_t                 res_r, res_nxt;
  logic                             out_valid_r;

  // Take the next word when the output register is free or being drained
  assign pop = !q_empty && (!out_valid_r || out_ch.ready);

  assign size      = long_r ? ypd_pkg::LONG_LEN : ypd_pkg::SHORT_LEN;
  assign count_inc = byte_count_r + 1'b1;
  assign crc_upd   = ypd_pkg::crc16_byte(crc_r, q_item.data);

  // Next phase and result
  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    long_nxt       = long_r;
    seq_nxt        = seq_r;
    seqc_nxt       = seqc_r;
    crc_nxt        = crc_r;

    res_nxt               = '0;
    res_nxt.out_byte      = q_item.data;
    res_nxt.status        = ypd_pkg::ST_BUSY;

    case (phase_r)
      ypd_pkg::PH_CANWAIT: begin
        res_nxt.packet_done = 1'b1;
        res_nxt.status      = ypd_pkg::ST_ABORT;
        phase_nxt           = ypd_pkg::PH_IDLE;
      end
      ypd_pkg::PH_IDLE: begin
        if (q_item.stop) begin
          res_nxt.packet_done = 1'b1;
          res_nxt.status      = ypd_pkg::ST_TIMEOUT;
        end else if (q_item.is_start) begin
          long_nxt  = q_item.is_long;
          phase_nxt = ypd_pkg::PH_SEQ;
        end else if (q_item.is_eot) begin
          res_nxt.packet_done = 1'b1;
          res_nxt.status      = ypd_pkg::ST_EOT;
        end else if (q_item.is_can) begin
          phase_nxt = ypd_pkg::PH_CANWAIT;
        end else begin
          res_nxt.packet_done = 1'b1;
          res_nxt.status      = ypd_pkg::ST_ABORT;
        end
      end
      ypd_pkg::PH_SEQ: begin
        if (q_item.stop) begin
          res_nxt.packet_done = 1'b1;
          res_nxt.status      = ypd_pkg::ST_TIMEOUT;
          phase_nxt           = ypd_pkg::PH_IDLE;
        end else begin
          seq_nxt              = q_item.data;
          res_nxt.block_number = q_item.data;
          phase_nxt            = ypd_pkg::PH_SEQC;
        end
      end
      ypd_pkg::PH_SEQC, ypd_pkg::PH_DATA, ypd_pkg::PH_CRCHI, ypd_pkg::PH_CRCLO: begin
        res_nxt.block_number = seq_r;
        if (q_item.stop) begin
          res_nxt.packet_done = 1'b1;
          res_nxt.status      = ypd_pkg::ST_TIMEOUT;
          phase_nxt           = ypd_pkg::PH_IDLE;
        end else if (phase_r == ypd_pkg::PH_SEQC) begin
          seqc_nxt       = q_item.data;
          crc_nxt        = '0;
          byte_count_nxt = '0;
          phase_nxt      = ypd_pkg::PH_DATA;
        end else if (phase_r == ypd_pkg::PH_DATA) begin
          crc_nxt               = crc_upd;
          res_nxt.payload_valid = 1'b1;
          byte_count_nxt        = count_inc;
          if (count_inc >= size) begin
            phase_nxt = ypd_pkg::PH_CRCHI;
          end
        end else if (phase_r == ypd_pkg::PH_CRCHI) begin
          crc_nxt   = crc_upd;
          phase_nxt = ypd_pkg::PH_CRCLO;
        end else begin
          // Trailer low byte closes the packet
          crc_nxt             = crc_upd;
          res_nxt.packet_done = 1'b1;
          phase_nxt           = ypd_pkg::PH_IDLE;
          if ((seq_r == (seqc_r ^ ypd_pkg::SEQ_MASK)) && (crc_upd == '0)) begin
            res_nxt.status  = ypd_pkg::ST_GOOD;
            res_nxt.pay_len = size;
          end else begin
            res_nxt.status = ypd_pkg::ST_CORRUPT;
          end
        end
      end
      default: begin
        phase_nxt = ypd_pkg::PH_IDLE;
      end
    endcase
  end

  // Receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ypd_pkg::PH_IDLE;
      byte_count_r <= '0;
      long_r       <= 1'b0;
      seq_r        <= '0;
      seqc_r       <= '0;
      crc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop) begin
        phase_r      <= phase_nxt;
        byte_count_r <= byte_count_nxt;
        long_r       <= long_nxt;
        seq_r        <= seq_nxt;
        seqc_r       <= seqc_nxt;
        crc_r        <= crc_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = res_r.out_byte;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.packet_done   = res_r.packet_done;
  assign out_ch.status        = res_r.status;
  assign out_ch.pay_len       = res_r.pay_len;
  assign out_ch.block_number  = res_r.block_number;

endmodule

FILE: rtl/ymodem_packet_deframer_core.sv
// YMODEM packet deframer.
// in_ch carries one received serial word per handshake: rx_byte with its
// timed_out and cancel flags. out_ch returns exactly one result word for
// every input word: the echoed byte, a payload marker, and on the word that
// ends a packet or event the final status, good-packet length and block
// number. SOH opens a 128-byte packet, STX a 1024-byte one; CRC-16/XMODEM
// over payload and trailer and the block number complement are checked.
// Throughput is one word per cycle while out_ch.ready is held high: the
// CRC is updated a full byte per cycle in the back end, which sets the
// rate. A result word is registered: each accepted word is written into
// the front queue and then loaded into the output register when the back
// end pops it. Reset (rst_n low, synchronous) empties the queue, drops
// any pending result and returns the receiver to idle awaiting a start
// byte. When the receiver stalls out_ch, the result is held, the queue
// keeps accepting until it is full, and then in_ch.ready drops.
module ymodem_packet_deframer_core #(
  parameter int unsigned QDEPTH = ypd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  ypd_in_if.sink     in_ch,
  ypd_out_if.source  out_ch
);

  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  ypd_pkg::item_t  push_item;
  ypd_pkg::item_t  pop_item;

  // Accept and classify incoming words
  ypd_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple front and back
  ypd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  // Run framing, sequence and CRC checks
  ypd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (pop_item),
    .pop     (pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  // A finished event always carries a final status, busy words never do
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.packet_done == (out_ch.status != ypd_pkg::ST_BUSY)))
    else $error("packet_done and status disagree");

  // Only a good packet reports a length, and it is one of the two sizes
  a_good_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.status == ypd_pkg::ST_GOOD) ?
      ((out_ch.pay_len == ypd_pkg::SHORT_LEN) ||
       (out_ch.pay_len == ypd_pkg::LONG_LEN)) :
      (out_ch.pay_len == '0)))
    else $error("bad pay_len for status");

  // A payload byte never closes a packet
  a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload_valid) |-> !out_ch.packet_done)
    else $error("payload byte marked as packet end");

  // The queue never overflows: no accept while the queue is full and the back end is stalled
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !pop) |=> !$rose(q_empty) && q_full)
    else $error("queue state lost while full");
`endif

endmodule

FILE: test/tb_top.sv
module tb_top;
  import ypd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned TOTAL_ITEMS  = RANDOM_ITEMS;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned PRESSURE_AT  = 300;
  localparam int unsigned PRESSURE_LEN = 150;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              timed_out;
    logic              cancel;
  } rx_word_t;

  typedef enum int unsigned {FLAW_NONE, FLAW_SEQ, FLAW_DATA, FLAW_CRC} flaw_t;

  logic clk = 1'b0;
  logic rst_n;

  ypd_in_if  in_ch ();
  ypd_out_if out_ch ();

  ymodem_packet_deframer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rx_word_t    rx_words_q[$];
  result_t     frame_results_q[$];
  int unsigned mismatch_count = 0;

  // Mirror of the receiver state
  phase_t              rx_phase;
  logic [LEN_W-1:0]    data_count;
  logic                long_pkt;
  logic [BYTE_W-1:0]   seq_num;
  logic [BYTE_W-1:0]   seq_inv;
  logic [CRC_W-1:0]    crc_run;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CRC-16/XMODEM, one bit at a time, MSB first
  function automatic logic [CRC_W-1:0] crc_xmodem_step(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    logic             fb;
    int               i;
    c = crc;
    for (i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ d[i];
      c  = {c[CRC_W-2:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Advance the mirrored receiver by one word and return its result word
  function automatic result_t deframe_step(input logic [BYTE_W-1:0] b, input logic tmo,
                                           input logic cnc);
    result_t          r;
    logic [LEN_W-1:0] size;
    r          = '0;
    r.out_byte = tmo ? '0 : b;
    r.status   = ST_BUSY;
    size       = long_pkt ? LONG_LEN : SHORT_LEN;
    if (rx_phase == PH_CANWAIT) begin
      // anything after CAN aborts, flags included
      r.packet_done = 1'b1;
      r.status      = ST_ABORT;
      rx_phase      = PH_IDLE;
    end else if (rx_phase == PH_IDLE) begin
      if (tmo || cnc) begin
        r.packet_done = 1'b1;
        r.status      = ST_TIMEOUT;
      end else if (b == CODE_SOH || b == CODE_STX) begin
        long_pkt = (b == CODE_STX);
        rx_phase = PH_SEQ;
      end else if (b == CODE_EOT) begin
        r.packet_done = 1'b1;
        r.status      = ST_EOT;
      end else if (b == CODE_CAN) begin
        rx_phase = PH_CANWAIT;
      end else begin
        r.packet_done = 1'b1;
        r.status      = ST_ABORT;
      end
    end else if (tmo || cnc) begin
      r.packet_done  = 1'b1;
      r.status       = ST_TIMEOUT;
      r.block_number = (rx_phase == PH_SEQ) ? '0 : seq_num;
      rx_phase       = PH_IDLE;
    end else begin
      case (rx_phase)
        PH_SEQ: begin
          seq_num        = b;
          r.block_number = b;
          rx_phase       = PH_SEQC;
        end
        PH_SEQC: begin
          seq_inv        = b;
          r.block_number = seq_num;
          crc_run        = '0;
          data_count     = '0;
          rx_phase       = PH_DATA;
        end
        PH_DATA: begin
          crc_run         = crc_xmodem_step(crc_run, b);
          r.payload_valid = 1'b1;
          r.block_number  = seq_num;
          data_count      = data_count + 1'b1;
          if (data_count >= size) rx_phase = PH_CRCHI;
        end
        PH_CRCHI: begin
          crc_run        = crc_xmodem_step(crc_run, b);
          r.block_number = seq_num;
          rx_phase       = PH_CRCLO;
        end
        PH_CRCLO: begin
          crc_run        = crc_xmodem_step(crc_run, b);
          r.block_number = seq_num;
          r.packet_done  = 1'b1;
          if (seq_num == (seq_inv ^ SEQ_MASK) && crc_run == '0) begin
            r.status  = ST_GOOD;
            r.pay_len = size;
          end else begin
            r.status = ST_CORRUPT;
          end
          rx_phase = PH_IDLE;
        end
        default: rx_phase = PH_IDLE;
      endcase
    end
    return r;
  endfunction

  function automatic rx_word_t mk_word(input logic [BYTE_W-1:0] b, input logic t, input logic c);
    rx_word_t w;
    w.rx_byte   = b;
    w.timed_out = t;
    w.cancel    = c;
    return w;
  endfunction

  function automatic void put(input logic [BYTE_W-1:0] b, input logic t, input logic c);
    rx_words_q.push_back(mk_word(b, t, c));
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return $urandom_range(20, 60);
    else if (r < 10) return $urandom_range(4, 12);
    else if (r < 35) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Queue one packet; optionally damage it or cut it short with a stop word
  task automatic add_packet(input bit is_long, input flaw_t flaw, input int unsigned cut);
    rx_word_t          pkt[$];
    int unsigned       n;
    int unsigned       bad_idx;
    int unsigned       i;
    int unsigned       k;
    logic [BYTE_W-1:0] seq;
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] mask;
    logic [CRC_W-1:0]  crc;
    n       = is_long ? LONG_PAYLOAD : SHORT_PAYLOAD;
    seq     = BYTE_W'($urandom_range(0, 255));
    mask    = BYTE_W'($urandom_range(1, 255));
    bad_idx = $urandom_range(0, n - 1);
    crc     = '0;
    pkt.push_back(mk_word(is_long ? CODE_STX : CODE_SOH, 1'b0, 1'b0));
    pkt.push_back(mk_word(seq, 1'b0, 1'b0));
    pkt.push_back(mk_word((seq ^ SEQ_MASK) ^ ((flaw == FLAW_SEQ) ? mask : '0), 1'b0, 1'b0));
    for (i = 0; i < n; i++) begin
      d   = BYTE_W'($urandom_range(0, 255));
      crc = crc_xmodem_step(crc, d);
      if (flaw == FLAW_DATA && i == bad_idx) d = d ^ mask;
      pkt.push_back(mk_word(d, 1'b0, 1'b0));
    end
    if (flaw == FLAW_CRC) crc = crc ^ ($urandom_range(0, 1) ? {mask, 8'h00} : {8'h00, mask});
    pkt.push_back(mk_word(crc[15:8], 1'b0, 1'b0));
    pkt.push_back(mk_word(crc[7:0], 1'b0, 1'b0));
    if (cut != 0 && cut < pkt.size()) begin
      pkt = pkt[0:cut-1];
      k   = $urandom_range(0, 2);
      pkt.push_back(mk_word(BYTE_W'($urandom_range(0, 255)), k != 1, k != 0));
    end
    foreach (pkt[j]) rx_words_q.push_back(pkt[j]);
  endtask

  // Drive input words: hold each until taken, then insert an optional gap
  int unsigned drv_gap;
  int unsigned drv_calm;

  always @(posedge clk) begin : word_driver
    rx_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_gap     = 0;
      drv_calm    = 0;
      rx_phase    = PH_IDLE;
      data_count  = '0;
      long_pkt    = 1'b0;
      seq_num     = '0;
      seq_inv     = '0;
      crc_run     = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        frame_results_q.push_back(deframe_step(in_ch.rx_byte, in_ch.timed_out, in_ch.cancel));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_ch.valid <= 1'b0;
        end else if (rx_words_q.size() != 0) begin
          nxt = rx_words_q.pop_front();
          in_ch.rx_byte   <= nxt.rx_byte;
          in_ch.timed_out <= nxt.timed_out;
          in_ch.cancel    <= nxt.cancel;
          in_ch.valid     <= 1'b1;
          if (drv_calm > 0) begin
            drv_calm--;
          end else begin
            drv_gap = pick_gap();
            if ($urandom_range(0, 39) == 0) drv_calm = $urandom_range(30, 200);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Check result words and throttle ready; one long hold-off fills the block
  int unsigned mon_hold;
  int unsigned mon_calm;
  int unsigned results_seen;
  bit          pressure_done;

  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      mon_hold      = 0;
      mon_calm      = 0;
      results_seen  = 0;
      pressure_done = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_results_q.size() == 0) begin
          $error("result word with nothing expected: out_byte %0h status %0d",
                 out_ch.out_byte, out_ch.status);
          mismatch_count++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("out_byte", 16'(want.out_byte), 16'(out_ch.out_byte));
          check_field("payload_valid", 16'(want.payload_valid),
                      16'(out_ch.payload_valid));
          check_field("packet_done", 16'(want.packet_done), 16'(out_ch.packet_done));
          check_field("status", 16'(want.status), 16'(out_ch.status));
          check_field("pay_len", 16'(want.pay_len), 16'(out_ch.pay_len));
          check_field("block_number", 16'(want.block_number), 16'(out_ch.block_number));
        end
        results_seen++;
      end
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        mon_hold      = PRESSURE_LEN;
      end
      if (mon_hold > 0) begin
        mon_hold--;
        out_ch.ready <= 1'b0;
      end else if (mon_calm > 0) begin
        mon_calm--;
        out_ch.ready <= 1'b1;
      end else begin
        mon_hold = pick_gap();
        if (mon_hold > 0) begin
          mon_hold--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 39) == 0) mon_calm = $urandom_range(30, 200);
        end
      end
    end
  end

  // Stop the run if neither channel moves a word for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("[ymodem_packet_deframer_core] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned n;
    bit          go_long;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = '0;
    in_ch.timed_out = 1'b0;
    in_ch.cancel    = 1'b0;
    out_ch.ready    = 1'b0;

    // Idle-state cases: stray bytes, EOT, timeout and cancel flags
    put(8'h00, 1'b0, 1'b0);
    put(8'hff, 1'b0, 1'b0);
    put(CODE_EOT, 1'b0, 1'b0);
    put(8'h55, 1'b1, 1'b0);
    put(8'haa, 1'b0, 1'b1);
    put(8'hff, 1'b1, 1'b1);
    // CAN followed by a byte, a second CAN, a timeout and a cancel
    put(CODE_CAN, 1'b0, 1'b0);
    put(8'h33, 1'b0, 1'b0);
    put(CODE_CAN, 1'b0, 1'b0);
    put(CODE_CAN, 1'b0, 1'b0);
    put(CODE_CAN, 1'b0, 1'b0);
    put(8'h7e, 1'b1, 1'b0);
    put(CODE_CAN, 1'b0, 1'b0);
    put(CODE_EOT, 1'b0, 1'b1);
    // Stops inside a packet: on the block number, its complement and the payload
    put(CODE_SOH, 1'b0, 1'b0);
    put(8'h5a, 1'b1, 1'b0);
    put(CODE_STX, 1'b0, 1'b0);
    put(8'hff, 1'b0, 1'b0);
    put(8'hab, 1'b0, 1'b1);
    put(CODE_SOH, 1'b0, 1'b0);
    put(8'h80, 1'b0, 1'b0);
    put(8'h7f, 1'b0, 1'b0);
    put(8'h12, 1'b1, 1'b0);

    // Random traffic: short packets whole, damaged or cut, cut long ones, noise, EOT and CAN
    while (rx_words_q.size() < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        add_packet(1'b0, FLAW_NONE, 0);
      end else if (r < 55) begin
        add_packet(1'b0, flaw_t'($urandom_range(1, 3)), 0);
      end else if (r < 70) begin
        go_long = 1'($urandom_range(0, 1));
        add_packet(go_long, FLAW_NONE, $urandom_range(1, go_long ? 140 : 132));
      end else if (r < 85) begin
        n = $urandom_range(1, 4);
        repeat (n) put(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 7) == 0);
      end else if (r < 92) begin
        put(CODE_EOT, 1'b0, 1'b0);
      end else begin
        put(CODE_CAN, 1'b0, 1'b0);
        put(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to go in and every result to come out
    while (rx_words_q.size() != 0 || in_ch.valid || frame_results_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("[ymodem_packet_deframer_core] OK");
    end else begin
      $display("[ymodem_packet_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
